>>> sv/assert_macros.svh
// Assertion macros shared by the echo width capture RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ECV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ecv assertion failed");

`define ECV_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ecv forbidden condition seen");

`else

`define ECV_ASSERT(lbl, clk, rstn, prop)

`define ECV_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> sv/ecv_pkg.sv
// Types and constants shared by the echo width capture and vote filter.
package ecv_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int TIMER_BITS   = 16;
  localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic MODE_CAPTURE = 1'b0;
  localparam logic MODE_UPDATE  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [1:0]  channel;
    logic [15:0] timestamp;
  } ecv_in_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [15:0] filtered_width;
  } ecv_out_t;

  // One channel's complete state, held as a single memory word.
  typedef struct packed {
    logic                  phase;
    logic [TIMER_BITS-1:0] rise;
    logic [TIMER_BITS-1:0] width;
    logic [TIMER_BITS-1:0] hist_mid;
    logic [TIMER_BITS-1:0] hist_new;
    logic [TIMER_BITS-1:0] voted;
  } ecv_rec_t;

  localparam int REC_W = $bits(ecv_rec_t);

endpackage

>>> sv/echo_width_capture_vote_filter.sv
// Top level: echo pulse width capture with three-sample vote filter per channel.
// Path: an update is held in stage s1, then its result is registered onto out_valid.
// Throughput: one transaction per cycle unless stalled; state memory is read on accept
// and written back as the item leaves s1, with a one-entry bypass for back-to-back use.
// Reset: synchronous; channel entries read as zero until first written, no clearing pass.
module echo_width_capture_vote_filter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ecv_pkg::ecv_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ecv_pkg::ecv_out_t out_data
);
  import ecv_pkg::*;

  `include "assert_macros.svh"

  logic                  in_acc;
  logic                  in_ok;
  logic [CH_AW-1:0]      in_ch;

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_mode_r;
  logic [CH_AW-1:0]      s1_ch_r;
  logic [1:0]            s1_chan_r;
  logic [TIMER_BITS-1:0] s1_ts_r;
  logic                  s1_blocked;
  logic                  s1_adv;

  logic [CH_AW-1:0]      ram_ra;
  logic                  ram_we;
  logic [REC_W-1:0]      ram_rd;
  ecv_rec_t              rec_cur;
  ecv_rec_t              rec_new;

  logic [NUM_CHANNELS-1:0] vld_r;
  logic                  rd_vld_r;
  logic                  fwd_r;
  ecv_rec_t              last_wr_r;

  logic                  out_valid_r, out_valid_nxt;
  ecv_out_t              out_data_r;

  assign in_ok      = 32'(in_data.channel) < NUM_CHANNELS;
  assign in_ch      = CH_AW'(in_data.channel);
  assign s1_blocked = s1_valid_r && (s1_mode_r == MODE_UPDATE) && out_valid_r && out_stall;
  assign s1_adv     = s1_valid_r && !s1_blocked;
  assign in_stall   = s1_blocked;
  assign in_acc     = in_valid && !in_stall;

  always_comb begin
    priority if (in_acc && in_ok) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  assign ram_ra = s1_blocked ? s1_ch_r : in_ch;
  assign ram_we = s1_adv;

  ecv_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_CHANNELS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_ch_r),
    .wr_data (rec_new),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  always_comb begin
    if (fwd_r) begin
      rec_cur = last_wr_r;
    end else if (rd_vld_r) begin
      rec_cur = ecv_rec_t'(ram_rd);
    end else begin
      rec_cur = '0;
    end
  end

  ecv_vote u_vote (
    .mode    (s1_mode_r),
    .ts      (s1_ts_r),
    .rec_in  (rec_cur),
    .rec_out (rec_new)
  );

  always_comb begin
    priority if (s1_adv && (s1_mode_r == MODE_UPDATE)) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        vld_r[s1_ch_r] <= 1'b1;
      end
      rd_vld_r <= (32'(ram_ra) < NUM_CHANNELS) && vld_r[ram_ra];
      fwd_r    <= ram_we && (s1_ch_r == ram_ra);
    end
  end

  always_ff @(posedge clk) begin
    last_wr_r <= rec_new;
    if (in_acc) begin
      s1_mode_r <= in_data.mode;
      s1_ch_r   <= in_ch;
      s1_chan_r <= in_data.channel;
      s1_ts_r   <= TIMER_BITS'(in_data.timestamp);
    end
    if (s1_adv && (s1_mode_r == MODE_UPDATE)) begin
      out_data_r.out_channel    <= s1_chan_r;
      out_data_r.filtered_width <= 16'(rec_new.voted);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ECV_NEVER(a_stall_only_when_busy, clk, rst_n, in_stall && !s1_valid_r)
  `ECV_ASSERT(a_bypass_follows_write, clk, rst_n, fwd_r |-> $past(ram_we))
  `ECV_ASSERT(a_capture_no_result, clk, rst_n,
              (s1_adv && (s1_mode_r == MODE_CAPTURE) && !out_stall) |=> !out_valid_r)
  `ECV_ASSERT(a_update_gives_result, clk, rst_n,
              (s1_adv && (s1_mode_r == MODE_UPDATE)) |=> out_valid_r)

endmodule

>>> sv/ecv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ecv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/ecv_vote.sv
// Per-channel state update: edge capture, width measurement and three-sample vote.
module ecv_vote (
  input  logic                          mode,
  input  logic [ecv_pkg::TIMER_BITS-1:0] ts,
  input  ecv_pkg::ecv_rec_t             rec_in,
  output ecv_pkg::ecv_rec_t             rec_out
);
  import ecv_pkg::*;

  logic [TIMER_BITS-1:0] h0, h1, h2;
  logic [TIMER_BITS-1:0] d01, d12, d02;
  logic [TIMER_BITS-1:0] v;

  function automatic logic [TIMER_BITS-1:0] abs_gap(input logic [TIMER_BITS-1:0] a,
                                                    input logic [TIMER_BITS-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign h0 = rec_in.hist_mid;
  assign h1 = rec_in.hist_new;
  assign h2 = rec_in.width;

  assign d01 = abs_gap(h0, h1);
  assign d12 = abs_gap(h1, h2);
  assign d02 = abs_gap(h0, h2);

  always_comb begin
    priority if (d01 < d12 && d01 < d02) begin
      v = h0;
    end else if (d12 < d01 && d12 < d02) begin
      v = h1;
    end else if (d02 < d01 && d02 < d12) begin
      v = h2;
    end else begin
      v = rec_in.voted;
    end
  end

  always_comb begin
    rec_out = rec_in;
    if (mode == MODE_CAPTURE) begin
      if (!rec_in.phase) begin
        rec_out.rise = ts;
      end else begin
        rec_out.width = ts - rec_in.rise;
      end
      rec_out.phase = ~rec_in.phase;
    end else begin
      rec_out.hist_mid = h1;
      rec_out.hist_new = h2;
      rec_out.voted    = v;
    end
  end

endmodule

>>> verif/echo_width_capture_vote_filter_test.sv
// Testbench for the echo width capture block, checked against a predictor.
`timescale 1ns / 100ps

module echo_width_capture_vote_filter_test;
  import ecv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ecv_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ecv_out_t out_data;

  logic        phase_q [NUM_CHANNELS];
  logic [15:0] rise_q [NUM_CHANNELS];
  logic [15:0] width_q [NUM_CHANNELS];
  logic [15:0] voted_q [NUM_CHANNELS];
  logic [15:0] history_q [NUM_CHANNELS][3];
  logic [15:0] typical_width [NUM_CHANNELS];

  ecv_out_t pending_widths [$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       items_sent = 0;
  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;

  echo_width_capture_vote_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("echo_width_capture_vote_filter: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  function automatic logic [15:0] width_gap(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic void predict_vote(input ecv_in_t item);
    logic [15:0] gap01;
    logic [15:0] gap12;
    logic [15:0] gap02;
    logic [15:0] pick;
    ecv_out_t    result;
    int          ch;
    ch = int'(item.channel);
    if (ch >= NUM_CHANNELS) return;
    if (item.mode == MODE_CAPTURE) begin
      if (!phase_q[ch]) rise_q[ch] = item.timestamp;
      else width_q[ch] = item.timestamp - rise_q[ch];
      phase_q[ch] = ~phase_q[ch];
      return;
    end
    history_q[ch][0] = history_q[ch][1];
    history_q[ch][1] = history_q[ch][2];
    history_q[ch][2] = width_q[ch];
    gap01 = width_gap(history_q[ch][0], history_q[ch][1]);
    gap12 = width_gap(history_q[ch][1], history_q[ch][2]);
    gap02 = width_gap(history_q[ch][0], history_q[ch][2]);
    if (gap01 < gap12 && gap01 < gap02) pick = history_q[ch][0];
    else if (gap12 < gap01 && gap12 < gap02) pick = history_q[ch][1];
    else if (gap02 < gap01 && gap02 < gap12) pick = history_q[ch][2];
    else pick = voted_q[ch];
    voted_q[ch] = pick;
    result.out_channel = item.channel;
    result.filtered_width = pick;
    pending_widths.push_back(result);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("ERROR at cycle %0d: %s, got %0h, wanted %0h", cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    ecv_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_vote(in_data);
      if (out_valid && !out_stall) begin
        if (pending_widths.size() == 0) begin
          report_mismatch("unexpected result transaction", int'(out_data), 0);
        end else begin
          want = pending_widths.pop_front();
          if (out_data.out_channel !== want.out_channel) begin
            report_mismatch("out_channel", int'(out_data.out_channel),
                            int'(want.out_channel));
          end
          if (out_data.filtered_width !== want.filtered_width) begin
            report_mismatch("filtered_width", int'(out_data.filtered_width),
                            int'(want.filtered_width));
          end
        end
      end
    end
  end

  task automatic send_event(input logic mode, input logic [1:0] ch, input logic [15:0] ts);
    ecv_in_t item;
    item.mode = mode;
    item.channel = ch;
    item.timestamp = ts;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (ch < NUM_CHANNELS) items_sent++;
  endtask

  task automatic send_pulse(input logic [1:0] ch, input logic [15:0] rise, input logic [15:0] w);
    if (phase_q[ch]) send_event(MODE_CAPTURE, ch, 16'($urandom));
    send_event(MODE_CAPTURE, ch, rise);
    send_event(MODE_CAPTURE, ch, rise + w);
    send_event(MODE_UPDATE, ch, 16'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_widths.size() != 0);
  endtask

  task automatic test_reset_history();
    send_event(MODE_UPDATE, 2'd0, 16'hFFFF);
  endtask

  task automatic test_ignored_channel();
    send_event(MODE_CAPTURE, 2'd3, 16'hFFFF);
    send_event(MODE_UPDATE, 2'd3, 16'h0000);
  endtask

  task automatic test_width_wraparound();
    send_event(MODE_CAPTURE, 2'd1, 16'hFFF0);
    send_event(MODE_CAPTURE, 2'd1, 16'h0010);
    send_event(MODE_UPDATE, 2'd1, 16'h5A5A);
    send_event(MODE_CAPTURE, 2'd0, 16'h0000);
    send_event(MODE_CAPTURE, 2'd0, 16'hFFFF);
    send_event(MODE_UPDATE, 2'd0, 16'hA5A5);
  endtask

  task automatic test_vote_branches();
    send_pulse(2'd2, 16'($urandom), 16'd100);
    send_pulse(2'd2, 16'($urandom), 16'd102);
    send_pulse(2'd2, 16'($urandom), 16'd500);
    send_pulse(2'd2, 16'($urandom), 16'd498);
    send_pulse(2'd2, 16'($urandom), 16'd501);
    send_pulse(2'd2, 16'($urandom), 16'd504);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    int          start;
    int          kind;
    int          shape;
    logic [1:0]  ch;
    logic [15:0] w;
    start = items_sent;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    while (items_sent - start < count) begin
      kind = $urandom_range(99);
      ch = 2'($urandom_range(NUM_CHANNELS - 1));
      if (kind < 70) begin
        shape = $urandom_range(99);
        if (shape < 55) w = typical_width[ch] + 16'($urandom_range(6)) - 16'd3;
        else if (shape < 72) w = typical_width[ch];
        else if (shape < 86) w = 16'($urandom);
        else if (shape < 90) w = 16'hFFFF;
        else if (shape < 94) w = 16'h0000;
        else begin
          typical_width[ch] = 16'($urandom_range(4000));
          w = typical_width[ch];
        end
        send_pulse(ch, 16'($urandom), w);
      end else if (kind < 80) begin
        send_event(MODE_UPDATE, ch, 16'($urandom));
      end else if (kind < 90) begin
        send_event(MODE_CAPTURE, 2'($urandom_range(3)), 16'($urandom));
      end else if (kind < 98) begin
        send_event(1'($urandom), 2'd3, 16'($urandom));
      end else begin
        drain_results();
      end
    end
    drain_results();
  endtask

  initial begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      phase_q[c] = 1'b0;
      rise_q[c] = '0;
      width_q[c] = '0;
      voted_q[c] = '0;
      typical_width[c] = 16'($urandom_range(4000));
      for (int k = 0; k < 3; k++) history_q[c][k] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_history();
    test_ignored_channel();
    test_width_wraparound();
    test_vote_branches();
    drain_results();

    test_random_traffic(215, 0, 0);
    test_random_traffic(215, 58, 0);
    test_random_traffic(215, 0, 58);
    test_random_traffic(215, 21, 21);

    in_valid <= 1'b0;
    while (pending_widths.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("echo_width_capture_vote_filter: match");
    end else begin
      $display("echo_width_capture_vote_filter: mismatch");
    end
    $finish;
  end

endmodule
